// ===== sv/well_pkg.sv =====
// ----------------------------------------------------------------------------
// WELL1024a generator package
// Shared types and constants for the generator core and its submodules.
// ----------------------------------------------------------------------------
package well_pkg;

    localparam int RingWords = 32;
    localparam int IdxW      = $clog2(RingWords);
    localparam int WordW     = 32;

    localparam logic [WordW-1:0] SeedMult = 32'd1812433253;

    // Read steps of a draw, in the order the operands are fetched.
    localparam logic [2:0] RdV0   = 3'd0;
    localparam logic [2:0] RdTap1 = 3'd1;
    localparam logic [2:0] RdTap2 = 3'd2;
    localparam logic [2:0] RdTap3 = 3'd3;
    localparam logic [2:0] RdPrev = 3'd4;
    localparam logic [2:0] RdDone = 3'd5;

    localparam logic [IdxW-1:0] LastSlot = IdxW'(RingWords - 1);

    localparam logic REQ_RESEED = 1'b0;
    localparam logic REQ_DRAW   = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEED,
        ST_READ,
        ST_MIX,
        ST_STORE
    } state_t;

    typedef struct packed {
        logic [WordW-1:0] v0;
        logic [WordW-1:0] m1;
        logic [WordW-1:0] m2;
        logic [WordW-1:0] m3;
        logic [WordW-1:0] z0;
    } draw_ops_t;

    typedef struct packed {
        logic [WordW-1:0] z3;
        logic [WordW-1:0] z4;
    } mix_res_t;

endpackage

// ===== sv/well_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module well_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== sv/well_mix_unit.sv =====
// ----------------------------------------------------------------------------
// WELL1024a mixing unit
// Shared arithmetic for the seed fill step and the draw recurrence.
// ----------------------------------------------------------------------------
module well_mix_unit (
    input  logic [well_pkg::WordW-1:0] seed_word,
    input  logic [well_pkg::IdxW-1:0]  slot,
    input  well_pkg::draw_ops_t        ops,
    output logic [well_pkg::WordW-1:0] seed_next,
    output well_pkg::mix_res_t         mix
);

    logic [well_pkg::WordW-1:0] folded;
    logic [well_pkg::WordW-1:0] z1;
    logic [well_pkg::WordW-1:0] z2;

    assign folded    = seed_word ^ {{30{seed_word[31]}}, seed_word[31:30]};
    assign seed_next = well_pkg::WordW'(well_pkg::SeedMult * folded)
                       + well_pkg::WordW'(slot);

    assign z1 = ops.v0 ^ ops.m1 ^ (ops.m1 >> 8);
    assign z2 = ops.m2 ^ (ops.m2 << 19) ^ ops.m3 ^ (ops.m3 << 14);

    assign mix.z3 = z1 ^ z2;
    assign mix.z4 = ops.z0 ^ (ops.z0 << 11) ^ z1 ^ (z1 << 7) ^ z2 ^ (z2 << 13);

endmodule

// ===== sv/well1024a_generator_core.sv =====
// ----------------------------------------------------------------------------
// WELL1024a generator core
// Pseudo-random word generator over a 32-word state ring held in a RAM.
// ----------------------------------------------------------------------------
// Requests arrive on the s_* stream: s_tuser selects reseed (0) or draw (1),
// and s_tdata carries the 64-bit seed and the wanted bit count. A reseed gives
// no result; a draw gives one word on the m_* stream.
// Each request is handled by a small sequencer around one mixing unit and a
// single-port-read ring RAM, so s_tready is high only while the core is idle.
// A reseed writes the two seed halves to ring words 0 and 1, then fills the
// rest through the seed multiplier, one ring word per cycle, then goes idle.
// A draw fetches five ring words one per cycle through the RAM read port,
// mixes them, then writes the two new words; its result enters the output
// register as the core returns to idle to take the next request.
// A waiting result sits in the output register, and the core keeps taking
// requests; a draw that finishes while the receiver stalls holds in its last
// step until the output register is free.
// Reset clears the sequencer, the ring index and the output valid flag. The
// ring words are undefined until the first reseed, so a draw must follow one.
// ----------------------------------------------------------------------------
module well1024a_generator_core #(
    parameter int TAP_ONE   = 3,
    parameter int TAP_TWO   = 24,
    parameter int TAP_THREE = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // seed_value[63:0], bit_count[69:64], zero pad
    input  logic        s_tuser,   // req_type[0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // random_value[31:0]
);

    localparam int IW = well_pkg::IdxW;
    localparam int WW = well_pkg::WordW;

    well_pkg::state_t    state_reg, state_next;
    logic [IW-1:0]       idx_reg, idx_next;
    logic [IW-1:0]       cnt_reg, cnt_next;
    logic [63:0]         seed_reg, seed_next_val;
    logic [5:0]          bits_reg, bits_next;
    logic [WW-1:0]       wa_reg, wa_next;
    logic [WW-1:0]       wb_reg, wb_next;
    well_pkg::draw_ops_t ops_reg, ops_next;
    logic [WW-1:0]       z4_reg, z4_next;
    logic                out_valid_reg, out_valid_next;
    logic [WW-1:0]       out_data_reg, out_data_next;

    logic                ram_wr_en;
    logic [IW-1:0]       ram_wr_addr;
    logic [WW-1:0]       ram_wr_data;
    logic [IW-1:0]       ram_rd_addr;
    logic [WW-1:0]       ram_rd_data;

    logic [WW-1:0]       seed_step;
    well_pkg::mix_res_t  mix;
    logic [IW-1:0]       prev_idx;
    logic [5:0]          shift_amt;
    logic [WW-1:0]       draw_value;

    well_ram #(
        .WIDTH(WW),
        .DEPTH(well_pkg::RingWords)
    ) u_ring (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    well_mix_unit u_mix (
        .seed_word(wa_reg),
        .slot     (cnt_reg),
        .ops      (ops_reg),
        .seed_next(seed_step),
        .mix      (mix)
    );

    assign prev_idx  = idx_reg - IW'(1);
    assign shift_amt = 6'd32 - bits_reg;

    always_comb
    begin
        if (bits_reg == 6'd0)
        begin
            draw_value = '0;
        end
        else if (bits_reg[5])
        begin
            draw_value = z4_reg;
        end
        else
        begin
            draw_value = z4_reg >> shift_amt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= well_pkg::ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seed_reg     <= seed_next_val;
        bits_reg     <= bits_next;
        wa_reg       <= wa_next;
        wb_reg       <= wb_next;
        ops_reg      <= ops_next;
        z4_reg       <= z4_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        seed_next_val  = seed_reg;
        bits_next      = bits_reg;
        wa_next        = wa_reg;
        wb_next        = wb_reg;
        ops_next       = ops_reg;
        z4_next        = z4_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = idx_reg;
        ram_wr_data    = mix.z3;
        ram_rd_addr    = idx_reg;
        s_tready       = 1'b0;

        unique case (state_reg)
            well_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cnt_next      = '0;
                    seed_next_val = s_tdata[63:0];
                    bits_next     = s_tdata[69:64];
                    if (s_tuser == well_pkg::REQ_RESEED)
                    begin
                        state_next = well_pkg::ST_SEED;
                    end
                    else
                    begin
                        state_next = well_pkg::ST_READ;
                    end
                end
            end

            well_pkg::ST_SEED:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cnt_reg;
                if (cnt_reg == IW'(0))
                begin
                    ram_wr_data = seed_reg[63:32];
                end
                else if (cnt_reg == IW'(1))
                begin
                    ram_wr_data = seed_reg[31:0];
                end
                else
                begin
                    ram_wr_data = seed_step;
                end
                wa_next  = wb_reg;
                wb_next  = ram_wr_data;
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg == well_pkg::LastSlot)
                begin
                    idx_next   = '0;
                    state_next = well_pkg::ST_IDLE;
                end
            end

            well_pkg::ST_READ:
            begin
                case (cnt_reg[2:0])
                    well_pkg::RdV0:   ram_rd_addr = idx_reg;
                    well_pkg::RdTap1: ram_rd_addr = idx_reg + IW'(TAP_ONE);
                    well_pkg::RdTap2: ram_rd_addr = idx_reg + IW'(TAP_TWO);
                    well_pkg::RdTap3: ram_rd_addr = idx_reg + IW'(TAP_THREE);
                    default:          ram_rd_addr = prev_idx;
                endcase
                case (cnt_reg[2:0])
                    well_pkg::RdTap1: ops_next.v0 = ram_rd_data;
                    well_pkg::RdTap2: ops_next.m1 = ram_rd_data;
                    well_pkg::RdTap3: ops_next.m2 = ram_rd_data;
                    well_pkg::RdPrev: ops_next.m3 = ram_rd_data;
                    well_pkg::RdDone: ops_next.z0 = ram_rd_data;
                    default:          ops_next    = ops_reg;
                endcase
                cnt_next = cnt_reg + IW'(1);
                if (cnt_reg[2:0] == well_pkg::RdDone)
                begin
                    state_next = well_pkg::ST_MIX;
                end
            end

            well_pkg::ST_MIX:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = idx_reg;
                ram_wr_data = mix.z3;
                z4_next     = mix.z4;
                state_next  = well_pkg::ST_STORE;
            end

            well_pkg::ST_STORE:
            begin
                ram_wr_addr = prev_idx;
                ram_wr_data = z4_reg;
                if (!out_valid_reg || m_tready)
                begin
                    ram_wr_en      = 1'b1;
                    idx_next       = prev_idx;
                    out_valid_next = 1'b1;
                    out_data_next  = draw_value;
                    state_next     = well_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = well_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
